@@ rtl/core/lpg_pkg.sv @@
// Shared widths and constants for the lexicographic permutation generator.
package lpg_pkg;

    localparam int SLOTS   = 8;
    localparam int ELEM_W  = 3;
    localparam int RANK_W  = 16;
    localparam int SIZE_W  = 4;
    localparam int RESET_SIZE = 8;

    // Rank of the descending permutation for each element count, n! - 1.
    localparam logic [RANK_W-1:0] LAST_RANK [SLOTS+1] = '{
        16'd0, 16'd0, 16'd1, 16'd5, 16'd23, 16'd119, 16'd719, 16'd5039, 16'd40319
    };

endpackage

@@ rtl/core/lpg_if.sv @@
// Request and result channel interfaces.
interface lpg_req_if;
    import lpg_pkg::*;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface lpg_res_if;
    import lpg_pkg::*;
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_0;
    logic [ELEM_W-1:0] element_1;
    logic [ELEM_W-1:0] element_2;
    logic [ELEM_W-1:0] element_3;
    logic [ELEM_W-1:0] element_4;
    logic [ELEM_W-1:0] element_5;
    logic [ELEM_W-1:0] element_6;
    logic [ELEM_W-1:0] element_7;
    logic [RANK_W-1:0] rank;
    logic              is_last;

    modport source (output valid, output element_0, output element_1, output element_2,
                    output element_3, output element_4, output element_5,
                    output element_6, output element_7, output rank, output is_last,
                    input ready);
    modport sink   (input valid, input element_0, input element_1, input element_2,
                    input element_3, input element_4, input element_5,
                    input element_6, input element_7, input rank, input is_last,
                    output ready);
endinterface

@@ rtl/core/lpg_next.sv @@
// Combinational successor: pivot, swap and tail reversal, plus rank and last flag.
module lpg_next #(
    parameter int MAX_SIZE = 8
) (
    input  logic [MAX_SIZE-1:0][lpg_pkg::ELEM_W-1:0] perm,
    input  logic [lpg_pkg::SIZE_W-1:0]               n,
    input  logic [lpg_pkg::RANK_W-1:0]               rank,
    input  logic                                     restart,
    input  logic                                     started,
    output logic [MAX_SIZE-1:0][lpg_pkg::ELEM_W-1:0] perm_next,
    output logic [lpg_pkg::RANK_W-1:0]               rank_next,
    output logic                                     is_last
);
    import lpg_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIZE);

    logic [IDX_W-1:0]                  piv;
    logic [IDX_W-1:0]                  succ;
    logic                              found;
    logic [ELEM_W-1:0]                 piv_val;
    logic [MAX_SIZE-1:0][ELEM_W-1:0]   swapped;
    logic [MAX_SIZE-1:0][ELEM_W-1:0]   advanced;
    logic [4:0]                        ridx;

    always_comb
    begin
        piv   = '0;
        found = 1'b0;
        for (int i = 0; i < MAX_SIZE - 1; i++)
        begin
            if ((i + 1 < int'(n)) && (perm[i] < perm[i+1]))
            begin
                piv   = IDX_W'(i);
                found = 1'b1;
            end
        end

        // tail after the pivot is descending: rightmost larger value is the successor
        piv_val = perm[piv];
        succ    = piv;
        for (int j = 0; j < MAX_SIZE; j++)
        begin
            if ((j > int'(piv)) && (j < int'(n)) && (perm[j] > piv_val))
                succ = IDX_W'(j);
        end

        swapped       = perm;
        swapped[piv]  = perm[succ];
        swapped[succ] = piv_val;

        advanced = swapped;
        ridx     = '0;
        for (int k = 0; k < MAX_SIZE; k++)
        begin
            ridx = 5'(n) + 5'(piv) - 5'(k);
            if ((k > int'(piv)) && (k < int'(n)))
                advanced[k] = swapped[ridx[IDX_W-1:0]];
        end

        if (restart || !started || !found)
        begin
            for (int k = 0; k < MAX_SIZE; k++)
                perm_next[k] = ELEM_W'(k);
            rank_next = '0;
        end
        else
        begin
            perm_next = advanced;
            rank_next = rank + RANK_W'(1);
        end

        is_last = (rank_next == LAST_RANK[n]);
    end

endmodule

@@ rtl/core/lexicographic_permutation_generator.sv @@
// Top level: permutation state, successor logic and registered result word.
//
//  channel  dir  fields                                   handshake
//  req      in   restart                                  valid/ready
//  res      out  element_0..element_7, rank, is_last      valid/ready
//  cfg      in   cfg_wdata (perm_size)                    cfg_we, no ready
//
// One request word per cycle while req.ready; result is valid in the cycle after.
// The successor is computed in a single pass from the stored permutation.
// Reset and any size write bring back the identity with rank zero.
// req.ready is low only while a result word is held and res.ready is low.
module lexicographic_permutation_generator #(
    parameter int MAX_SIZE = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpg_pkg::SIZE_W-1:0] cfg_wdata,
    lpg_req_if.sink                    req,
    lpg_res_if.source                  res
);
    import lpg_pkg::*;

    logic [MAX_SIZE-1:0][ELEM_W-1:0] perm_reg;
    logic [MAX_SIZE-1:0][ELEM_W-1:0] perm_next;
    logic [RANK_W-1:0]               rank_reg;
    logic [RANK_W-1:0]               rank_next;
    logic                            started_reg;
    logic [SIZE_W-1:0]               size_reg;
    logic [SIZE_W-1:0]               n;
    logic                            last_next;

    logic                            res_valid_reg;
    logic [SLOTS-1:0][ELEM_W-1:0]    elem_reg;
    logic [SLOTS-1:0][ELEM_W-1:0]    elem_next;
    logic [RANK_W-1:0]               res_rank_reg;
    logic                            res_last_reg;
    logic                            take;

    always_comb
    begin
        if (size_reg == '0)
            n = SIZE_W'(1);
        else if (size_reg > SIZE_W'(MAX_SIZE))
            n = SIZE_W'(MAX_SIZE);
        else
            n = size_reg;
    end

    lpg_next #(.MAX_SIZE(MAX_SIZE)) u_next (
        .perm      (perm_reg),
        .n         (n),
        .rank      (rank_reg),
        .restart   (req.restart),
        .started   (started_reg),
        .perm_next (perm_next),
        .rank_next (rank_next),
        .is_last   (last_next)
    );

    always_comb
    begin
        elem_next = '0;
        for (int k = 0; k < MAX_SIZE; k++)
        begin
            if (k < int'(n))
                elem_next[k] = perm_next[k];
        end
    end

    assign req.ready = !res_valid_reg || res.ready;
    assign take      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_SIZE; k++)
                perm_reg[k] <= ELEM_W'(k);
            rank_reg      <= '0;
            started_reg   <= 1'b0;
            size_reg      <= SIZE_W'(RESET_SIZE);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
                for (int k = 0; k < MAX_SIZE; k++)
                    perm_reg[k] <= ELEM_W'(k);
                rank_reg    <= '0;
                started_reg <= 1'b0;
            end
            else if (take)
            begin
                perm_reg    <= perm_next;
                rank_reg    <= rank_next;
                started_reg <= 1'b1;
            end

            if (take)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            elem_reg     <= elem_next;
            res_rank_reg <= rank_next;
            res_last_reg <= last_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.element_0 = elem_reg[0];
    assign res.element_1 = elem_reg[1];
    assign res.element_2 = elem_reg[2];
    assign res.element_3 = elem_reg[3];
    assign res.element_4 = elem_reg[4];
    assign res.element_5 = elem_reg[5];
    assign res.element_6 = elem_reg[6];
    assign res.element_7 = elem_reg[7];
    assign res.rank      = res_rank_reg;
    assign res.is_last   = res_last_reg;

endmodule
